FILE: hdl/sfs_pkg.sv
// Shared constants, codes, types and helpers of the scanline seed fill step.
// Used by sfs_seed_stack and scanline_seed_fill_step; depends on nothing.
package sfs_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int STACK_DEPTH  = 4096;

  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int KIND_W  = 2;
  localparam int MODE_W  = 2;
  localparam int XC_W    = X_W + 1;
  localparam int YC_W    = Y_W + 1;
  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W  = $clog2(STACK_DEPTH);
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int FADDR_W = $clog2(FRAME_PIXELS);

  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOUNDARY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILLED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_POP,
    ST_WALK,
    ST_PUSH,
    ST_RESULT
  } sfs_state_t;

  typedef struct packed {
    logic           push;
    logic           pop;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } sfs_stack_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               overflow;
  } sfs_stack_stat_t;

  // Coordinates carry one extra bit so that one step off either edge stays visible.
  function automatic logic in_frame(input logic [XC_W-1:0] x, input logic [YC_W-1:0] y);
    return (x < XC_W'(FRAME_WIDTH)) && (y < YC_W'(FRAME_HEIGHT));
  endfunction

  function automatic logic [FADDR_W-1:0] pix_addr(input logic [XC_W-1:0] x,
                                                  input logic [YC_W-1:0] y);
    return FADDR_W'(FADDR_W'(y) * FADDR_W'(FRAME_WIDTH) + FADDR_W'(x));
  endfunction

endpackage

FILE: hdl/sfs_seed_stack.sv
// Seed stack: a synchronous memory of (x,y) seeds, its level and the sticky overflow flag.
// Depends on sfs_pkg.
module sfs_seed_stack (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sfs_pkg::sfs_stack_req_t         req,
  output sfs_pkg::sfs_stack_stat_t        stat,
  output logic [sfs_pkg::X_W-1:0]         pop_x,
  output logic [sfs_pkg::Y_W-1:0]         pop_y
);

  logic [sfs_pkg::X_W+sfs_pkg::Y_W-1:0] stack_mem [sfs_pkg::STACK_DEPTH];
  logic [sfs_pkg::X_W+sfs_pkg::Y_W-1:0] rd_data_r;
  logic [sfs_pkg::LEVEL_W-1:0]          level_r;
  logic                                 overflow_r;
  logic [sfs_pkg::LEVEL_W-1:0]          pop_lvl;
  logic                                 full;

  assign full    = (level_r == sfs_pkg::LEVEL_W'(sfs_pkg::STACK_DEPTH));
  assign pop_lvl = level_r - sfs_pkg::LEVEL_W'(1);

  // Entries at and above the level are never read, so the memory needs no clearing.
  always_ff @(posedge clk) begin
    if (req.push && !full) begin
      stack_mem[level_r[sfs_pkg::SIDX_W-1:0]] <= {req.y, req.x};
    end
    if (req.pop) begin
      rd_data_r <= stack_mem[pop_lvl[sfs_pkg::SIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      if (req.push) begin
        if (full) begin
          overflow_r <= 1'b1;
        end else begin
          level_r <= level_r + sfs_pkg::LEVEL_W'(1);
        end
      end else if (req.pop) begin
        level_r <= pop_lvl;
      end
    end
  end

  assign stat.level    = level_r;
  assign stat.overflow = overflow_r;
  assign pop_x         = rd_data_r[sfs_pkg::X_W-1:0];
  assign pop_y         = rd_data_r[sfs_pkg::X_W+sfs_pkg::Y_W-1:sfs_pkg::X_W];

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    req.pop |-> (level_r != '0))
    else $error("seed stack popped while empty");

  a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
    (req.push && !req.pop && !full) |=> (level_r == $past(level_r) + sfs_pkg::LEVEL_W'(1)))
    else $error("seed stack level did not rise on push");

  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    (req.pop && !req.push) |=> (level_r == $past(level_r) - sfs_pkg::LEVEL_W'(1)))
    else $error("seed stack level did not fall on pop");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (req.push && full) |=> (overflow_r && level_r == $past(level_r)))
    else $error("push on a full seed stack was not dropped");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag cleared without reset");
`endif

endmodule

FILE: hdl/scanline_seed_fill_step.sv
// Top level of the scanline seed fill step: frame memory, fill sequencer and result register.
// Depends on sfs_pkg and sfs_seed_stack.
//
//  Channel  Direction  Handshake             Payload
//  in       request    in_valid / in_stall   mode, pos_x, pos_y, pixel_kind
//  out      result     out_valid / out_stall read_kind, span_*, stack_empty/overflow/level
//
// After reset the frame memory is swept to empty, one pixel per cycle; in_stall stays
// high during the sweep. A pixel write or a seed push goes from the idle state straight
// to the result state, and a pixel read passes through the read state on its way there.
// A fill step pops a seed and walks one column at a time over every pixel filled and the
// boundary that ends each direction: the single read port of the frame memory fetches five
// pixels per column, and each seed pushed takes its own turn on the stack write port. A
// popped seed that is not empty is dropped.
// Requests are taken one at a time. A finished result waits in the output register, so the
// next request is accepted while out_stall holds the previous result.
module scanline_seed_fill_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfs_pkg::MODE_W-1:0]      in_mode,
  input  logic [sfs_pkg::X_W-1:0]         in_pos_x,
  input  logic [sfs_pkg::Y_W-1:0]         in_pos_y,
  input  logic [sfs_pkg::KIND_W-1:0]      in_pixel_kind,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfs_pkg::KIND_W-1:0]      out_read_kind,
  output logic                            out_span_valid,
  output logic [sfs_pkg::Y_W-1:0]         out_span_row,
  output logic [sfs_pkg::X_W-1:0]         out_span_left,
  output logic [sfs_pkg::X_W-1:0]         out_span_right,
  output logic                            out_stack_empty,
  output logic                            out_stack_overflow,
  output logic [sfs_pkg::LEVEL_W-1:0]     out_stack_level
);

  // Phase of the per-column walk: phases 0 to 4 fetch, the last phase decides.
  localparam logic [2:0] PH_EVAL = 3'd5;

  sfs_pkg::sfs_state_t state_r, state_nxt;

  // Frame memory with one write port and one registered read port.
  logic [sfs_pkg::KIND_W-1:0]  frame_mem [sfs_pkg::FRAME_PIXELS];
  logic [sfs_pkg::KIND_W-1:0]  rd_data_r;
  logic                        rd_in_r;
  logic                        rd_en;
  logic                        rd_ok;
  logic [sfs_pkg::XC_W-1:0]    rd_x;
  logic [sfs_pkg::YC_W-1:0]    rd_y;
  logic                        wr_en;
  logic [sfs_pkg::XC_W-1:0]    wr_x;
  logic [sfs_pkg::YC_W-1:0]    wr_y;
  logic [sfs_pkg::KIND_W-1:0]  wr_kind;
  logic [sfs_pkg::FADDR_W-1:0] wr_addr;
  logic [sfs_pkg::KIND_W-1:0]  kind_rd;
  logic [sfs_pkg::FADDR_W-1:0] clr_addr_r;

  sfs_pkg::sfs_stack_req_t     stk_req;
  sfs_pkg::sfs_stack_stat_t    stk_stat;
  logic [sfs_pkg::X_W-1:0]     stk_pop_x;
  logic [sfs_pkg::Y_W-1:0]     stk_pop_y;

  // Walk state.
  logic [2:0]                  phase_r;
  logic [sfs_pkg::XC_W-1:0]    t_r;
  logic [sfs_pkg::X_W-1:0]     seed_x_r;
  logic [sfs_pkg::Y_W-1:0]     y_r;
  logic                        dir_left_r;
  logic                        first_r;
  logic [sfs_pkg::KIND_W-1:0]  nb_r [4];
  logic [sfs_pkg::KIND_W-1:0]  seed_up_r, seed_dn_r, last_up_r, last_dn_r;
  logic                        after_result_r;

  // Two pending seed pushes, taken in order by the push state.
  logic                        pa_v_r, pb_v_r;
  logic [sfs_pkg::X_W-1:0]     pa_x_r, pb_x_r;
  logic [sfs_pkg::Y_W-1:0]     pa_y_r, pb_y_r;

  // Result being built and the output register.
  logic [sfs_pkg::KIND_W-1:0]  res_kind_r;
  logic                        res_span_r;
  logic [sfs_pkg::X_W-1:0]     res_left_r, res_right_r;
  logic                        out_valid_r;
  logic                        out_free;

  logic                        in_acc;
  logic                        eval;
  logic                        stop;
  logic                        skip;
  logic                        pa_go, pb_go;
  logic [sfs_pkg::XC_W-1:0]    t_side;
  logic [sfs_pkg::XC_W-1:0]    t_step;
  logic [sfs_pkg::XC_W-1:0]    ex;
  logic [sfs_pkg::YC_W-1:0]    y_up, y_dn;

  assign in_stall  = (state_r != sfs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign kind_rd = rd_in_r ? rd_data_r : sfs_pkg::KIND_BOUNDARY;

  // Neighbor coordinates around the walked column; the row below row 0 wraps to all ones.
  assign y_up   = {1'b0, y_r} + sfs_pkg::YC_W'(1);
  assign y_dn   = {1'b0, y_r} - sfs_pkg::YC_W'(1);
  assign t_side = dir_left_r ? (t_r - sfs_pkg::XC_W'(1)) : (t_r + sfs_pkg::XC_W'(1));
  assign t_step = t_side;

  // Decision at the end of a column: nb_r holds the current pixel, the far and near
  // pixels above, and the far pixel below; the near pixel below arrives now.
  assign eval = (state_r == sfs_pkg::ST_WALK) && (phase_r == PH_EVAL);
  assign stop = (nb_r[0] == sfs_pkg::KIND_BOUNDARY);
  assign skip = first_r && (nb_r[0] != sfs_pkg::KIND_EMPTY);

  always_comb begin
    if (stop) begin
      // The walk ended one column back from t; seed the rows there if they are empty.
      ex    = dir_left_r ? (t_r + sfs_pkg::XC_W'(1)) : (t_r - sfs_pkg::XC_W'(1));
      pa_go = (last_up_r == sfs_pkg::KIND_EMPTY);
      pb_go = (last_dn_r == sfs_pkg::KIND_EMPTY);
    end else begin
      ex    = t_r;
      pa_go = (nb_r[1] == sfs_pkg::KIND_BOUNDARY) && (nb_r[2] == sfs_pkg::KIND_EMPTY);
      pb_go = (nb_r[3] == sfs_pkg::KIND_BOUNDARY) && (kind_rd == sfs_pkg::KIND_EMPTY);
    end
  end

  sfs_seed_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stk_req),
    .stat  (stk_stat),
    .pop_x (stk_pop_x),
    .pop_y (stk_pop_y)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfs_pkg::ST_CLEAR: begin
        if (clr_addr_r == sfs_pkg::FADDR_W'(sfs_pkg::FRAME_PIXELS - 1)) begin
          state_nxt = sfs_pkg::ST_IDLE;
        end
      end
      sfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            sfs_pkg::MODE_WRITE: state_nxt = sfs_pkg::ST_RESULT;
            sfs_pkg::MODE_PUSH:  state_nxt = sfs_pkg::ST_RESULT;
            sfs_pkg::MODE_READ:  state_nxt = sfs_pkg::ST_READ;
            sfs_pkg::MODE_FILL: begin
              state_nxt = (stk_stat.level != '0) ? sfs_pkg::ST_POP : sfs_pkg::ST_RESULT;
            end
            default: state_nxt = sfs_pkg::ST_RESULT;
          endcase
        end
      end
      sfs_pkg::ST_READ:  state_nxt = sfs_pkg::ST_RESULT;
      sfs_pkg::ST_POP:   state_nxt = sfs_pkg::ST_WALK;
      sfs_pkg::ST_WALK: begin
        if (phase_r == PH_EVAL) begin
          state_nxt = skip ? sfs_pkg::ST_RESULT : sfs_pkg::ST_PUSH;
        end
      end
      sfs_pkg::ST_PUSH: begin
        if (!pa_v_r && !pb_v_r) begin
          state_nxt = after_result_r ? sfs_pkg::ST_RESULT : sfs_pkg::ST_WALK;
        end
      end
      sfs_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = sfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfs_pkg::ST_IDLE;
    endcase
  end

  // Memory and stack controls.
  always_comb begin
    rd_en   = 1'b0;
    rd_x    = t_r;
    rd_y    = {1'b0, y_r};
    wr_en   = 1'b0;
    wr_x    = t_r;
    wr_y    = {1'b0, y_r};
    wr_kind = sfs_pkg::KIND_FILLED;
    stk_req = '0;
    unique case (state_r)
      sfs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_kind = sfs_pkg::KIND_EMPTY;
      end
      sfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            sfs_pkg::MODE_WRITE: begin
              wr_x    = {1'b0, in_pos_x};
              wr_y    = {1'b0, in_pos_y};
              wr_kind = in_pixel_kind;
              wr_en   = (in_pixel_kind != sfs_pkg::KIND_INVALID) &&
                        sfs_pkg::in_frame(wr_x, wr_y);
            end
            sfs_pkg::MODE_PUSH: begin
              stk_req.push = 1'b1;
              stk_req.x    = in_pos_x;
              stk_req.y    = in_pos_y;
            end
            sfs_pkg::MODE_READ: begin
              rd_en = 1'b1;
              rd_x  = {1'b0, in_pos_x};
              rd_y  = {1'b0, in_pos_y};
            end
            sfs_pkg::MODE_FILL: begin
              stk_req.pop = (stk_stat.level != '0);
            end
            default: stk_req = '0;
          endcase
        end
      end
      sfs_pkg::ST_WALK: begin
        rd_en = (phase_r != PH_EVAL);
        case (phase_r)
          3'd1: begin
            rd_x = t_side;
            rd_y = y_up;
          end
          3'd2: rd_y = y_up;
          3'd3: begin
            rd_x = t_side;
            rd_y = y_dn;
          end
          3'd4: rd_y = y_dn;
          default: rd_x = t_r;
        endcase
        wr_en = eval && !skip && !stop;
      end
      sfs_pkg::ST_PUSH: begin
        stk_req.push = pa_v_r || pb_v_r;
        stk_req.x    = pa_v_r ? pa_x_r : pb_x_r;
        stk_req.y    = pa_v_r ? pa_y_r : pb_y_r;
      end
      sfs_pkg::ST_READ, sfs_pkg::ST_POP, sfs_pkg::ST_RESULT: begin
        rd_en = 1'b0;
      end
      default: rd_en = 1'b0;
    endcase
  end

  assign rd_ok   = rd_en && sfs_pkg::in_frame(rd_x, rd_y);
  assign wr_addr = (state_r == sfs_pkg::ST_CLEAR) ? clr_addr_r : sfs_pkg::pix_addr(wr_x, wr_y);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_kind;
    end
    if (rd_ok) begin
      rd_data_r <= frame_mem[sfs_pkg::pix_addr(rd_x, rd_y)];
    end
    rd_in_r <= rd_ok;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfs_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      phase_r     <= '0;
      pa_v_r      <= 1'b0;
      pb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sfs_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + sfs_pkg::FADDR_W'(1);
      end
      if (state_r == sfs_pkg::ST_WALK && phase_r != PH_EVAL) begin
        phase_r <= phase_r + 3'd1;
      end else begin
        phase_r <= '0;
      end
      if (eval && !skip) begin
        pa_v_r <= pa_go;
        pb_v_r <= pb_go;
      end else if (state_r == sfs_pkg::ST_PUSH) begin
        if (pa_v_r) begin
          pa_v_r <= 1'b0;
        end else begin
          pb_v_r <= 1'b0;
        end
      end
      if (state_r == sfs_pkg::ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk and result payload.
  always_ff @(posedge clk) begin
    if (state_r == sfs_pkg::ST_IDLE && in_acc) begin
      res_kind_r  <= sfs_pkg::KIND_EMPTY;
      res_span_r  <= 1'b0;
      res_left_r  <= '0;
      res_right_r <= '0;
    end
    if (state_r == sfs_pkg::ST_READ) begin
      res_kind_r <= kind_rd;
    end
    if (state_r == sfs_pkg::ST_POP) begin
      seed_x_r   <= stk_pop_x;
      y_r        <= stk_pop_y;
      t_r        <= {1'b0, stk_pop_x};
      dir_left_r <= 1'b0;
      first_r    <= 1'b1;
    end
    if (state_r == sfs_pkg::ST_WALK && phase_r != '0 && phase_r != PH_EVAL) begin
      nb_r[2'(phase_r - 3'd1)] <= kind_rd;
    end
    if (eval) begin
      pa_x_r <= ex[sfs_pkg::X_W-1:0];
      pb_x_r <= ex[sfs_pkg::X_W-1:0];
      pa_y_r <= y_up[sfs_pkg::Y_W-1:0];
      pb_y_r <= y_dn[sfs_pkg::Y_W-1:0];
      priority if (skip) begin
        after_result_r <= 1'b1;
      end else if (stop && !dir_left_r) begin
        // Rightward run done: turn around and start left of the seed.
        res_right_r    <= ex[sfs_pkg::X_W-1:0];
        dir_left_r     <= 1'b1;
        t_r            <= {1'b0, seed_x_r} - sfs_pkg::XC_W'(1);
        last_up_r      <= seed_up_r;
        last_dn_r      <= seed_dn_r;
        after_result_r <= 1'b0;
      end else if (stop) begin
        res_left_r     <= ex[sfs_pkg::X_W-1:0];
        res_span_r     <= 1'b1;
        after_result_r <= 1'b1;
      end else begin
        last_up_r      <= nb_r[2];
        last_dn_r      <= kind_rd;
        if (first_r) begin
          seed_up_r <= nb_r[2];
          seed_dn_r <= kind_rd;
        end
        first_r        <= 1'b0;
        t_r            <= t_step;
        after_result_r <= 1'b0;
      end
    end
    if (state_r == sfs_pkg::ST_RESULT && out_free) begin
      out_read_kind      <= res_kind_r;
      out_span_valid     <= res_span_r;
      out_span_row       <= res_span_r ? y_r : '0;
      out_span_left      <= res_left_r;
      out_span_right     <= res_right_r;
      out_stack_empty    <= (stk_stat.level == '0);
      out_stack_overflow <= stk_stat.overflow;
      out_stack_level    <= stk_stat.level;
    end
  end

endmodule

FILE: tb/scanline_seed_fill_step_checker.sv
// Checker of the scanline seed fill step: watches both channels, keeps its own frame and
// seed stack, and compares every result with the oldest prediction. Depends on sfs_pkg.
module scanline_seed_fill_step_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [sfs_pkg::MODE_W-1:0]  in_mode,
  input  logic [sfs_pkg::X_W-1:0]     in_pos_x,
  input  logic [sfs_pkg::Y_W-1:0]     in_pos_y,
  input  logic [sfs_pkg::KIND_W-1:0]  in_pixel_kind,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sfs_pkg::KIND_W-1:0]  out_read_kind,
  input  logic                        out_span_valid,
  input  logic [sfs_pkg::Y_W-1:0]     out_span_row,
  input  logic [sfs_pkg::X_W-1:0]     out_span_left,
  input  logic [sfs_pkg::X_W-1:0]     out_span_right,
  input  logic                        out_stack_empty,
  input  logic                        out_stack_overflow,
  input  logic [sfs_pkg::LEVEL_W-1:0] out_stack_level,
  output int                          mismatches,
  output int                          pending
);
  import sfs_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]  read_kind;
    logic               span_valid;
    logic [Y_W-1:0]     span_row;
    logic [X_W-1:0]     span_left;
    logic [X_W-1:0]     span_right;
    logic               stack_empty;
    logic               stack_overflow;
    logic [LEVEL_W-1:0] stack_level;
  } fill_result_t;

  logic [KIND_W-1:0] frame_kind [FRAME_PIXELS];
  int                seed_x [STACK_DEPTH];
  int                seed_y [STACK_DEPTH];
  int                seed_count;
  logic              seeds_dropped;
  fill_result_t      result_fifo [$];

  function automatic logic [KIND_W-1:0] kind_at(int x, int y);
    if (x < 0 || y < 0 || x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return KIND_BOUNDARY;
    return frame_kind[y * FRAME_WIDTH + x];
  endfunction

  function automatic void paint(int x, int y);
    if (x >= 0 && y >= 0 && x < FRAME_WIDTH && y < FRAME_HEIGHT)
      frame_kind[y * FRAME_WIDTH + x] = KIND_FILLED;
  endfunction

  function automatic void add_seed(int x, int y);
    if (seed_count >= STACK_DEPTH) begin
      seeds_dropped = 1'b1;
      return;
    end
    seed_x[seed_count] = x & 16'hFFFF;
    seed_y[seed_count] = y & 16'hFFFF;
    seed_count++;
  endfunction

  // Applies one request to the local frame and stack and returns the result it causes.
  function automatic fill_result_t apply_request(logic [MODE_W-1:0] mode, int px, int py,
                                                 logic [KIND_W-1:0] kind);
    fill_result_t r;
    int x, y, t;
    r = '0;
    case (mode)
      MODE_WRITE: begin
        if (kind != KIND_INVALID && px < FRAME_WIDTH && py < FRAME_HEIGHT)
          frame_kind[py * FRAME_WIDTH + px] = kind;
      end
      MODE_PUSH: add_seed(px, py);
      MODE_READ: r.read_kind = kind_at(px, py);
      default: begin
        if (seed_count > 0) begin
          seed_count--;
          x = seed_x[seed_count];
          y = seed_y[seed_count];
          if (kind_at(x, y) == KIND_EMPTY) begin
            t = x;
            while (kind_at(t, y) != KIND_BOUNDARY) begin
              paint(t, y);
              if (kind_at(t + 1, y + 1) == KIND_BOUNDARY && kind_at(t, y + 1) == KIND_EMPTY)
                add_seed(t, y + 1);
              if (kind_at(t + 1, y - 1) == KIND_BOUNDARY && kind_at(t, y - 1) == KIND_EMPTY)
                add_seed(t, y - 1);
              t++;
            end
            r.span_right = X_W'(t - 1);
            if (kind_at(t - 1, y + 1) == KIND_EMPTY) add_seed(t - 1, y + 1);
            if (kind_at(t - 1, y - 1) == KIND_EMPTY) add_seed(t - 1, y - 1);
            t = x - 1;
            while (kind_at(t, y) != KIND_BOUNDARY) begin
              paint(t, y);
              if (kind_at(t - 1, y + 1) == KIND_BOUNDARY && kind_at(t, y + 1) == KIND_EMPTY)
                add_seed(t, y + 1);
              if (kind_at(t - 1, y - 1) == KIND_BOUNDARY && kind_at(t, y - 1) == KIND_EMPTY)
                add_seed(t, y - 1);
              t--;
            end
            r.span_left = X_W'(t + 1);
            if (kind_at(t + 1, y + 1) == KIND_EMPTY) add_seed(t + 1, y + 1);
            if (kind_at(t + 1, y - 1) == KIND_EMPTY) add_seed(t + 1, y - 1);
            r.span_valid = 1'b1;
            r.span_row = Y_W'(y);
          end
        end
      end
    endcase
    r.stack_empty    = (seed_count == 0);
    r.stack_overflow = seeds_dropped;
    r.stack_level    = LEVEL_W'(seed_count);
    return r;
  endfunction

  initial begin
    foreach (frame_kind[i]) frame_kind[i] = KIND_EMPTY;
    seed_count    = 0;
    seeds_dropped = 1'b0;
    mismatches    = 0;
  end

  assign pending = result_fifo.size();

  always @(posedge clk) begin
    fill_result_t want, got;
    if (rst_n && in_valid && !in_stall)
      result_fifo.push_back(apply_request(in_mode, int'(in_pos_x), int'(in_pos_y),
                                          in_pixel_kind));
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_read_kind, out_span_valid, out_span_row, out_span_left, out_span_right,
              out_stack_empty, out_stack_overflow, out_stack_level};
      if (result_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = result_fifo.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

endmodule

FILE: tb/scanline_seed_fill_step_tb.sv
// Testbench top of the scanline seed fill step: clock, reset, request and result traffic,
// watchdog and verdict. Depends on sfs_pkg, scanline_seed_fill_step and its checker.
module scanline_seed_fill_step_tb;
  import sfs_pkg::*;

  // Box in the top left corner that random fills stay inside: column BOX_W and row BOX_H
  // are walls, the frame edges close the other two sides.
  localparam int BOX_W      = 32;
  localparam int BOX_H      = 16;
  localparam int ITEMS      = 700;
  localparam int HOLD_LEN   = 300;
  // The limit must also cover the memory sweep after reset, which moves no request.
  localparam int IDLE_LIMIT = 4 * FRAME_PIXELS;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [X_W-1:0]      in_pos_x;
  logic [Y_W-1:0]      in_pos_y;
  logic [KIND_W-1:0]   in_pixel_kind;
  logic                out_valid;
  logic                out_stall;
  logic [KIND_W-1:0]   out_read_kind;
  logic                out_span_valid;
  logic [Y_W-1:0]      out_span_row;
  logic [X_W-1:0]      out_span_left;
  logic [X_W-1:0]      out_span_right;
  logic                out_stack_empty;
  logic                out_stack_overflow;
  logic [LEVEL_W-1:0]  out_stack_level;
  int                  mismatches;
  int                  pending;
  logic                burst;
  logic                hold_req;
  int                  idle_cycles;

  scanline_seed_fill_step DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_pos_x, .in_pos_y, .in_pixel_kind,
    .out_valid, .out_stall, .out_read_kind, .out_span_valid, .out_span_row, .out_span_left,
    .out_span_right, .out_stack_empty, .out_stack_overflow, .out_stack_level
  );

  scanline_seed_fill_step_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_pos_x, .in_pos_y, .in_pixel_kind,
    .out_valid, .out_stall, .out_read_kind, .out_span_valid, .out_span_row, .out_span_left,
    .out_span_right, .out_stack_empty, .out_stack_overflow, .out_stack_level,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request after a random gap and returns at the edge that accepts it.
  // With a zero gap in_valid simply stays high for the next request.
  task automatic send_request(logic [MODE_W-1:0] mode, int x, int y, logic [KIND_W-1:0] kind);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_pos_x      <= X_W'(x);
    in_pos_y      <= Y_W'(y);
    in_pixel_kind <= kind;
    do @(posedge clk); while (in_stall);
  endtask

  // Coordinates of a pixel that lies off the frame in x, in y, or in both.
  function automatic int off_x();
    return $urandom_range(0, 1) ? $urandom_range(FRAME_WIDTH, 1023) : $urandom_range(0, 1023);
  endfunction

  function automatic int off_y(int x);
    return (x >= FRAME_WIDTH) ? $urandom_range(0, 511) : $urandom_range(FRAME_HEIGHT, 511);
  endfunction

  // Result side: a random stall before each result, and one long hold-off on request so
  // that the block backs up and stalls its input.
  initial begin
    int wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        wait_cycles = burst ? 0 : $urandom_range(0, 3);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or a result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick, x, y;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mode       <= MODE_WRITE;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_pixel_kind <= KIND_EMPTY;
    burst         = 1'b0;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A fill step with nothing on the stack comes first.
    send_request(MODE_FILL, 0, 0, KIND_EMPTY);
    send_request(MODE_READ, 0, 0, KIND_EMPTY);
    send_request(MODE_WRITE, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, KIND_FILLED);
    send_request(MODE_READ, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, KIND_EMPTY);
    // A kind of 3 is ignored, so the pixel must still read as filled.
    send_request(MODE_WRITE, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, KIND_INVALID);
    send_request(MODE_READ, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, KIND_EMPTY);
    // Writes off the frame are dropped and reads there see a boundary.
    send_request(MODE_WRITE, 1023, 511, KIND_BOUNDARY);
    send_request(MODE_READ, 1023, 511, KIND_EMPTY);
    send_request(MODE_READ, FRAME_WIDTH, 0, KIND_EMPTY);
    // A seed off the frame is taken, then skipped when popped.
    send_request(MODE_PUSH, 1023, 511, KIND_EMPTY);
    send_request(MODE_FILL, 0, 0, KIND_EMPTY);
    // Seed on a non-empty pixel: popped and discarded.
    send_request(MODE_PUSH, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, KIND_EMPTY);
    send_request(MODE_FILL, 0, 0, KIND_EMPTY);

    // Walls of the box, with no gaps so the stretch also runs without idling.
    burst = 1'b1;
    for (int i = 0; i <= BOX_H; i++) send_request(MODE_WRITE, BOX_W, i, KIND_BOUNDARY);
    for (int i = 0; i < BOX_W; i++) send_request(MODE_WRITE, i, BOX_H, KIND_BOUNDARY);
    burst = 1'b0;

    // A fill from the corner of the box, walking against the frame edge.
    send_request(MODE_WRITE, 5, 1, KIND_BOUNDARY);
    send_request(MODE_PUSH, 0, 0, KIND_EMPTY);
    send_request(MODE_FILL, 0, 0, KIND_EMPTY);
    send_request(MODE_FILL, 0, 0, KIND_EMPTY);
    send_request(MODE_READ, 3, 0, KIND_EMPTY);

    // Random part: mostly writes, seeds and fill steps inside the box, with reads anywhere,
    // and writes and seeds off the frame and writes below the box as noise.
    for (int n = 0; n < ITEMS; n++) begin
      if (n % 150 == 75) burst = ~burst;
      if (n == ITEMS / 2) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (n % 120 == 119) begin
        // Reopen a row of the box so that later fills find empty pixels again.
        y = $urandom_range(0, BOX_H - 1);
        for (int i = 0; i < BOX_W; i++) send_request(MODE_WRITE, i, y, KIND_EMPTY);
      end else if (pick < 35) begin
        if (pick < 22) begin
          x = $urandom_range(0, BOX_W - 1);
          y = $urandom_range(0, BOX_H - 1);
        end else if (pick < 28) begin
          x = off_x();
          y = off_y(x);
        end else begin
          x = $urandom_range(0, FRAME_WIDTH - 1);
          y = $urandom_range(100, FRAME_HEIGHT - 1);
        end
        send_request(MODE_WRITE, x, y, KIND_W'($urandom_range(0, 3)));
      end else if (pick < 60) begin
        if (pick < 54) begin
          x = $urandom_range(0, BOX_W - 1);
          y = $urandom_range(0, BOX_H - 1);
        end else begin
          x = off_x();
          y = off_y(x);
        end
        send_request(MODE_PUSH, x, y, KIND_W'($urandom_range(0, 3)));
      end else if (pick < 85) begin
        send_request(MODE_FILL, $urandom_range(0, 1023), $urandom_range(0, 511),
                     KIND_W'($urandom_range(0, 3)));
      end else begin
        send_request(MODE_READ, $urandom_range(0, 1023), $urandom_range(0, 511),
                     KIND_W'($urandom_range(0, 3)));
      end
    end

    // Drain a few seeds, then one last push.
    for (int i = 0; i < 6; i++) send_request(MODE_FILL, 0, 0, KIND_EMPTY);
    send_request(MODE_PUSH, FRAME_WIDTH - 1, 0, KIND_EMPTY);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sfs_pkg.sv
hdl/sfs_seed_stack.sv
hdl/scanline_seed_fill_step.sv
tb/scanline_seed_fill_step_checker.sv
tb/scanline_seed_fill_step_tb.sv
